/* hdl/cdbu_pkg.sv */
`timescale 1ns / 1ps

package cdbu_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned CtlW     = 9;
  localparam int unsigned StatusW  = 6;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 32;

  typedef enum logic [1:0] {
    OP_FETCH = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_RSVD = 2'd3
  } size_kind_t;

  typedef enum logic [1:0] {
    EXC_NONE = 2'd0,
    EXC_BRK  = 2'd1,
    EXC_ADDR = 2'd2
  } exc_t;

  // register index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_CONTROL    = 3'd0,
    REG_CODE_ADDR  = 3'd1,
    REG_CODE_MASK  = 3'd2,
    REG_DATA_ADDR  = 3'd3,
    REG_DATA_MASK  = 3'd4,
    REG_CHECK_ALGN = 3'd5
  } reg_idx_t;

  // control bit positions
  localparam int unsigned CtlMaster = 0;
  localparam int unsigned CtlKernel = 1;
  localparam int unsigned CtlUser   = 2;
  localparam int unsigned CtlTrap   = 3;
  localparam int unsigned CtlCode   = 4;
  localparam int unsigned CtlData   = 5;
  localparam int unsigned CtlRead   = 6;
  localparam int unsigned CtlWrite  = 7;
  localparam int unsigned CtlTrace  = 8;

  // status bit positions
  localparam int unsigned StAny   = 0;
  localparam int unsigned StCode  = 1;
  localparam int unsigned StData  = 2;
  localparam int unsigned StRead  = 3;
  localparam int unsigned StWrite = 4;
  localparam int unsigned StTrace = 5;

  localparam logic [AddrW-1:0] PcStep = AddrW'(4);

  typedef struct packed {
    logic [CtlW-1:0]  control;
    logic [AddrW-1:0] code_addr;
    logic [AddrW-1:0] code_mask;
    logic [AddrW-1:0] data_addr;
    logic [AddrW-1:0] data_mask;
    logic             check_align;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         exception_kind;
    logic [StatusW-1:0] status_bits;
    logic               clear_cop_err;
  } result_t;

endpackage

/* hdl/cdbu_check.sv */
`timescale 1ns / 1ps

module cdbu_check
  import cdbu_pkg::*;
(
  input  cfg_t               cfg,
  input  logic [1:0]         opcode,
  input  logic [AddrW-1:0]   access_address,
  input  logic [1:0]         access_size,
  input  logic [AddrW-1:0]   program_counter,
  input  logic [StatusW-1:0] status,
  input  logic [AddrW-1:0]   prev_pc,
  output result_t            result,
  output logic [StatusW-1:0] status_nxt,
  output logic               prev_pc_we
);

  logic region_ok;
  logic code_hit;
  logic data_hit;
  logic is_fetch;
  logic is_data;
  logic is_write;
  logic trace_hit;
  logic fetch_misalign;
  logic data_misalign;
  logic trap;

  always_comb begin
    is_fetch = (opcode == OP_FETCH);
    is_write = (opcode == OP_WRITE);
    is_data  = (opcode == OP_READ) || is_write;
    trap     = cfg.control[CtlTrap];

    region_ok = cfg.control[CtlMaster] &&
                (access_address[AddrW-1] ? cfg.control[CtlKernel] : cfg.control[CtlUser]);

    code_hit = is_fetch && region_ok && cfg.control[CtlCode] &&
               (((access_address ^ cfg.code_addr) & cfg.code_mask) == '0);

    data_hit = is_data && region_ok && cfg.control[CtlData] &&
               (is_write ? cfg.control[CtlWrite] : cfg.control[CtlRead]) &&
               (((access_address ^ cfg.data_addr) & cfg.data_mask) == '0);

    // trace: pc should follow the previous fetch by one word
    trace_hit = cfg.control[CtlTrace] && (program_counter != (prev_pc + PcStep));

    fetch_misalign = cfg.check_align && (access_address[1:0] != 2'b00);
    case (access_size)
      SIZE_BYTE: data_misalign = 1'b0;
      SIZE_HALF: data_misalign = cfg.check_align && access_address[0];
      default:   data_misalign = cfg.check_align && (access_address[1:0] != 2'b00);
    endcase

    status_nxt            = status;
    result.exception_kind = EXC_NONE;
    result.clear_cop_err  = 1'b0;

    if (code_hit) begin
      status_nxt[StAny]  = 1'b1;
      status_nxt[StCode] = 1'b1;
      if (trace_hit) begin
        status_nxt[StTrace] = 1'b1;
      end
      if (trap) begin
        result.exception_kind = fetch_misalign ? EXC_ADDR : EXC_BRK;
      end
    end else if (data_hit) begin
      status_nxt[StAny]  = 1'b1;
      status_nxt[StData] = 1'b1;
      if (is_write) begin
        status_nxt[StWrite] = 1'b1;
      end else begin
        status_nxt[StRead] = 1'b1;
      end
      if (trap) begin
        result.exception_kind = data_misalign ? EXC_ADDR : EXC_BRK;
        result.clear_cop_err  = !data_misalign;
      end
    end

    result.status_bits = status_nxt;
    prev_pc_we         = is_fetch;
  end

endmodule

/* hdl/cpu_debug_breakpoint_unit.sv */
`timescale 1ns / 1ps
// A result is registered in out_r, or in skid_r while the output is stalled.
// Throughput: one access per cycle while in_stall is low; the check is a single
// masked compare per breakpoint between the input handshake and result register.
// A skid register keeps the input open for one transaction while a result waits.
// Reset (rst_n low, synchronous) clears status, previous pc and all config
// registers except check_alignment, which resets to 1.

module cpu_debug_breakpoint_unit
  import cdbu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [AddrW-1:0]   in_access_address,
  input  logic [1:0]         in_access_size,
  input  logic [AddrW-1:0]   in_program_counter,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_exception_kind,
  output logic [StatusW-1:0] out_status_bits,
  output logic               out_clear_coprocessor_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [PdataW-1:0]  pwdata,
  output logic [PdataW-1:0]  prdata,
  output logic               pready
);

  cfg_t               cfg_r;
  logic [StatusW-1:0] status_r;
  logic [AddrW-1:0]   prev_pc_r;

  result_t            res;
  logic [StatusW-1:0] status_nxt;
  logic               prev_pc_we;

  result_t            out_r;
  logic               out_valid_r;
  result_t            skid_r;
  logic               skid_valid_r;

  logic               in_acc;
  logic               out_free;
  logic               cfg_wr;
  reg_idx_t           reg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = reg_idx_t'(paddr[PaddrW-1:2]);
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (reg_idx)
      REG_CONTROL:    prdata = PdataW'(cfg_r.control);
      REG_CODE_ADDR:  prdata = cfg_r.code_addr;
      REG_CODE_MASK:  prdata = cfg_r.code_mask;
      REG_DATA_ADDR:  prdata = cfg_r.data_addr;
      REG_DATA_MASK:  prdata = cfg_r.data_mask;
      REG_CHECK_ALGN: prdata = PdataW'(cfg_r.check_align);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control     <= '0;
      cfg_r.code_addr   <= '0;
      cfg_r.code_mask   <= '0;
      cfg_r.data_addr   <= '0;
      cfg_r.data_mask   <= '0;
      cfg_r.check_align <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CONTROL:    cfg_r.control     <= pwdata[CtlW-1:0];
        REG_CODE_ADDR:  cfg_r.code_addr   <= pwdata;
        REG_CODE_MASK:  cfg_r.code_mask   <= pwdata;
        REG_DATA_ADDR:  cfg_r.data_addr   <= pwdata;
        REG_DATA_MASK:  cfg_r.data_mask   <= pwdata;
        REG_CHECK_ALGN: cfg_r.check_align <= pwdata[0];
        default: ;
      endcase
    end
  end

  cdbu_check u_check (
    .cfg             (cfg_r),
    .opcode          (in_opcode),
    .access_address  (in_access_address),
    .access_size     (in_access_size),
    .program_counter (in_program_counter),
    .status          (status_r),
    .prev_pc         (prev_pc_r),
    .result          (res),
    .status_nxt      (status_nxt),
    .prev_pc_we      (prev_pc_we)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r  <= '0;
      prev_pc_r <= '0;
    end else if (in_acc) begin
      status_r <= status_nxt;
      if (prev_pc_we) begin
        prev_pc_r <= in_program_counter;
      end
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_exception_kind          = out_r.exception_kind;
  assign out_status_bits             = out_r.status_bits;
  assign out_clear_coprocessor_error = out_r.clear_cop_err;

endmodule
